// File: rtl/core/unu_pkg.sv
// unu_pkg: types, widths and constants of the unit normal datapath
// no dependencies
`timescale 1ns / 1ps

package unu_pkg;

    localparam int COORD_BITS       = 24;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int LEN_W   = $clog2(CROSS_W + 1);
    localparam int M_W     = 30;
    localparam int SQR_W   = 2 * M_W;
    localparam int S_W     = SQR_W + 2;
    localparam int ROOT_W  = S_W / 2;
    localparam int Q_W     = NORMAL_FRAC_BITS + 1;
    localparam int NUM_W   = M_W + NORMAL_FRAC_BITS + 1;
    localparam int OUT_W   = 16;

    localparam int SQRT_CELLS = ROOT_W;
    localparam int DIV_CELLS  = Q_W;

    typedef struct packed {
        logic                         op;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] az;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by_coord;
        logic signed [COORD_BITS-1:0] bz;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
        logic signed [COORD_BITS-1:0] dz;
    } unu_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } unu_out_t;

    // control travelling alongside the data in every stage
    typedef struct packed {
        logic       valid;
        logic       op;
        logic       degen;
        logic [2:0] neg;
    } unu_ctl_t;

    localparam logic OP_2D = 1'b0;
    localparam logic OP_3D = 1'b1;

endpackage

// File: rtl/core/unu_if.sv
// unu_in_if, unu_out_if: valid/ready channels carrying the input and result items
// depends on unu_pkg
`timescale 1ns / 1ps

interface unu_in_if;
    import unu_pkg::*;
    logic    valid;
    logic    ready;
    unu_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface unu_out_if;
    import unu_pkg::*;
    logic     valid;
    logic     ready;
    unu_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/unu_front.sv
// unu_front: edge differences, cross product, magnitude scaling and sum of squares
// depends on unu_pkg
`timescale 1ns / 1ps

module unu_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  unu_pkg::unu_in_t              in_data,
    output unu_pkg::unu_ctl_t             ctl_out,
    output logic [unu_pkg::S_W-1:0]       s_out,
    output logic [2:0][unu_pkg::M_W-1:0]  m_out
);
    import unu_pkg::*;

    unu_ctl_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, c7_reg, c8_reg;
    unu_ctl_t c1_next, c4_next, c5_next;

    logic signed [DIFF_W-1:0]  e_reg [6];
    logic signed [DIFF_W-1:0]  e_next [6];
    logic signed [PROD_W-1:0]  p_reg [6];
    logic signed [DIFF_W-1:0]  e1x2_reg, e1y2_reg;
    logic signed [CROSS_W-1:0] c_reg [3];
    logic signed [CROSS_W-1:0] c_next [3];
    logic [CROSS_W-1:0]        mag_reg [3];
    logic [CROSS_W-1:0]        mag_next [3];
    logic [CROSS_W-1:0]        mag5_reg [3];
    logic [CROSS_W-1:0]        any_w;
    logic [LEN_W-1:0]          len_next, len_reg;
    logic [M_W-1:0]            m_next [3];
    logic [M_W-1:0]            m6_reg [3];
    logic [M_W-1:0]            m7_reg [3];
    logic [M_W-1:0]            m8_reg [3];
    logic [SQR_W-1:0]          sq_reg [3];
    logic [S_W-1:0]            s_reg;

    // stage 1: differences
    always_comb
    begin
        c1_next       = '0;
        c1_next.valid = in_valid;
        c1_next.op    = in_data.op;
        e_next[0] = {in_data.bx[COORD_BITS-1], in_data.bx}
                  - {in_data.ax[COORD_BITS-1], in_data.ax};
        e_next[1] = {in_data.by_coord[COORD_BITS-1], in_data.by_coord}
                  - {in_data.ay[COORD_BITS-1], in_data.ay};
        e_next[2] = {in_data.bz[COORD_BITS-1], in_data.bz}
                  - {in_data.az[COORD_BITS-1], in_data.az};
        e_next[3] = {in_data.dx[COORD_BITS-1], in_data.dx}
                  - {in_data.ax[COORD_BITS-1], in_data.ax};
        e_next[4] = {in_data.dy[COORD_BITS-1], in_data.dy}
                  - {in_data.ay[COORD_BITS-1], in_data.ay};
        e_next[5] = {in_data.dz[COORD_BITS-1], in_data.dz}
                  - {in_data.az[COORD_BITS-1], in_data.az};
    end

    // stage 3: cross product or in-plane normal
    always_comb
    begin
        if (c2_reg.op == OP_3D)
        begin
            c_next[0] = {p_reg[0][PROD_W-1], p_reg[0]} - {p_reg[1][PROD_W-1], p_reg[1]};
            c_next[1] = {p_reg[2][PROD_W-1], p_reg[2]} - {p_reg[3][PROD_W-1], p_reg[3]};
            c_next[2] = {p_reg[4][PROD_W-1], p_reg[4]} - {p_reg[5][PROD_W-1], p_reg[5]};
        end
        else
        begin
            c_next[0] = CROSS_W'(e1y2_reg);
            c_next[1] = CROSS_W'(0) - CROSS_W'(e1x2_reg);
            c_next[2] = '0;
        end
    end

    // stage 4: sign and magnitude
    always_comb
    begin
        c4_next = c3_reg;
        for (int i = 0; i < 3; i++)
        begin
            c4_next.neg[i] = c_reg[i][CROSS_W-1];
            mag_next[i]    = c_reg[i][CROSS_W-1] ? (CROSS_W'(0) - c_reg[i]) : c_reg[i];
        end
    end

    // stage 5: bit length of the largest magnitude
    always_comb
    begin
        any_w    = mag_reg[0] | mag_reg[1] | mag_reg[2];
        len_next = '0;
        for (int i = 0; i < CROSS_W; i++)
        begin
            if (any_w[i])
            begin
                len_next = LEN_W'(i + 1);
            end
        end
        c5_next       = c4_reg;
        c5_next.degen = (any_w == '0);
    end

    // stage 6: common scaling so the largest magnitude tops out at the msb
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (len_reg > LEN_W'(M_W))
            begin
                m_next[i] = M_W'(mag5_reg[i] >> (len_reg - LEN_W'(M_W)));
            end
            else
            begin
                m_next[i] = M_W'(mag5_reg[i] << (LEN_W'(M_W) - len_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
            c7_reg <= '0;
            c8_reg <= '0;
        end
        else if (en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c4_next;
            c5_reg <= c5_next;
            c6_reg <= c5_reg;
            c7_reg <= c6_reg;
            c8_reg <= c7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                e_reg[i] <= e_next[i];
            end
            p_reg[0] <= e_reg[1] * e_reg[5];
            p_reg[1] <= e_reg[2] * e_reg[4];
            p_reg[2] <= e_reg[2] * e_reg[3];
            p_reg[3] <= e_reg[0] * e_reg[5];
            p_reg[4] <= e_reg[0] * e_reg[4];
            p_reg[5] <= e_reg[1] * e_reg[3];
            e1x2_reg <= e_reg[0];
            e1y2_reg <= e_reg[1];
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i]    <= c_next[i];
                mag_reg[i]  <= mag_next[i];
                mag5_reg[i] <= mag_reg[i];
                m6_reg[i]   <= m_next[i];
                sq_reg[i]   <= m6_reg[i] * m6_reg[i];
                m7_reg[i]   <= m6_reg[i];
                m8_reg[i]   <= m7_reg[i];
            end
            len_reg <= len_next;
            s_reg   <= S_W'(sq_reg[0]) + S_W'(sq_reg[1]) + S_W'(sq_reg[2]);
        end
    end

    assign ctl_out = c8_reg;
    assign s_out   = s_reg;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_out[i] = m8_reg[i];
        end
    end

endmodule

// File: rtl/core/unu_sqrt_cell.sv
// unu_sqrt_cell: one result bit of the square root chain
// depends on unu_pkg
`timescale 1ns / 1ps

module unu_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  unu_pkg::unu_ctl_t             ctl_in,
    input  logic [unu_pkg::S_W-1:0]       v_in,
    input  logic [unu_pkg::S_W-1:0]       r_in,
    input  logic [2:0][unu_pkg::M_W-1:0]  m_in,
    output unu_pkg::unu_ctl_t             ctl_out,
    output logic [unu_pkg::S_W-1:0]       v_out,
    output logic [unu_pkg::S_W-1:0]       r_out,
    output logic [2:0][unu_pkg::M_W-1:0]  m_out
);
    import unu_pkg::*;

    localparam logic [S_W-1:0] BIT = S_W'(1) << (2 * K);

    unu_ctl_t            ctl_reg;
    logic [S_W:0]        trial;
    logic                take;
    logic [S_W-1:0]      v_next, r_next, v_reg, r_reg;
    logic [2:0][M_W-1:0] m_reg;

    always_comb
    begin
        trial  = {1'b0, r_in} + {1'b0, BIT};
        take   = ({1'b0, v_in} >= trial);
        v_next = take ? S_W'({1'b0, v_in} - trial) : v_in;
        r_next = take ? ((r_in >> 1) + BIT) : (r_in >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
            m_reg <= m_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign v_out   = v_reg;
    assign r_out   = r_reg;
    assign m_out   = m_reg;

endmodule

// File: rtl/core/unu_div_cell.sv
// unu_div_cell: one quotient bit for all three components
// depends on unu_pkg
`timescale 1ns / 1ps

module unu_div_cell #(
    parameter int I = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  unu_pkg::unu_ctl_t               ctl_in,
    input  logic [unu_pkg::ROOT_W-1:0]      root_in,
    input  logic [2:0][unu_pkg::NUM_W-1:0]  rem_in,
    input  logic [2:0][unu_pkg::Q_W-1:0]    q_in,
    output unu_pkg::unu_ctl_t               ctl_out,
    output logic [unu_pkg::ROOT_W-1:0]      root_out,
    output logic [2:0][unu_pkg::NUM_W-1:0]  rem_out,
    output logic [2:0][unu_pkg::Q_W-1:0]    q_out
);
    import unu_pkg::*;

    localparam logic [Q_W-1:0] QBIT = Q_W'(1) << I;

    unu_ctl_t              ctl_reg;
    logic [NUM_W:0]        dvs;
    logic [2:0][NUM_W-1:0] rem_next, rem_reg;
    logic [2:0][Q_W-1:0]   q_next, q_reg;
    logic [ROOT_W-1:0]     root_reg;

    always_comb
    begin
        dvs = (NUM_W + 1)'(root_in) << I;
        for (int c = 0; c < 3; c++)
        begin
            if ({1'b0, rem_in[c]} >= dvs)
            begin
                rem_next[c] = NUM_W'({1'b0, rem_in[c]} - dvs);
                q_next[c]   = q_in[c] | QBIT;
            end
            else
            begin
                rem_next[c] = rem_in[c];
                q_next[c]   = q_in[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            root_reg <= root_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;

endmodule

// File: rtl/core/unit_normal_unit_core.sv
// unit_normal_unit_core: top level of the unit normal pipeline
// depends on unu_pkg, unu_if, unu_front, unu_sqrt_cell, unu_div_cell
//
// usage: items arrive on req (op, points a, b, d in signed Q12.12), one
// result per item leaves on rsp (normal_x/y/z in Q1.14 and degenerate).
// op = 1 gives the normalised face normal (b-a)x(d-a), op = 0 the in-plane
// normal of edge a->b. a zero-length vector gives (0,0,1) in 3D mode and
// (0,0,0) in 2D mode, with degenerate set.
// throughput: one transfer per cycle on each side while the chain is not stalled.
// path: an accepted item passes through 8 front stages, a chain of 31
// square-root cells (one root bit each), a chain of 15 divider cells (one
// quotient bit each) and the output register.
// stall: the whole chain moves together; while rsp holds a result that is
// not taken, req.ready is low and every stage keeps its contents.
// reset clears all valid flags; data registers are not reset.
`timescale 1ns / 1ps

module unit_normal_unit_core (
    input  logic     clk,
    input  logic     rst_n,
    unu_in_if.sink   req,
    unu_out_if.source rsp
);
    import unu_pkg::*;

    localparam logic [Q_W-1:0]   ONE_Q   = Q_W'(2 ** NORMAL_FRAC_BITS);
    localparam logic [OUT_W-1:0] ONE_OUT = OUT_W'(2 ** NORMAL_FRAC_BITS);

    logic adv;

    unu_ctl_t            sq_ctl [SQRT_CELLS+1];
    logic [S_W-1:0]      sq_v   [SQRT_CELLS+1];
    logic [S_W-1:0]      sq_r   [SQRT_CELLS+1];
    logic [2:0][M_W-1:0] sq_m   [SQRT_CELLS+1];

    unu_ctl_t              dv_ctl  [DIV_CELLS+1];
    logic [ROOT_W-1:0]     dv_root [DIV_CELLS+1];
    logic [2:0][NUM_W-1:0] dv_rem  [DIV_CELLS+1];
    logic [2:0][Q_W-1:0]   dv_q    [DIV_CELLS+1];

    logic          out_valid_reg;
    unu_out_t      out_reg, out_next;
    logic [Q_W-1:0] q_sat [3];
    logic [OUT_W-1:0] comp [3];
    unu_ctl_t      last_ctl;

    assign adv       = !(out_valid_reg && !rsp.ready);
    assign req.ready = adv;

    unu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (req.valid),
        .in_data  (req.data),
        .ctl_out  (sq_ctl[0]),
        .s_out    (sq_v[0]),
        .m_out    (sq_m[0])
    );
    assign sq_r[0] = '0;

    for (genvar j = 0; j < SQRT_CELLS; j++)
    begin : g_sqrt
        unu_sqrt_cell #(.K(SQRT_CELLS - 1 - j)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .ctl_in  (sq_ctl[j]),
            .v_in    (sq_v[j]),
            .r_in    (sq_r[j]),
            .m_in    (sq_m[j]),
            .ctl_out (sq_ctl[j+1]),
            .v_out   (sq_v[j+1]),
            .r_out   (sq_r[j+1]),
            .m_out   (sq_m[j+1])
        );
    end

    // dividend: scaled magnitude plus half the root for rounding
    assign dv_ctl[0]  = sq_ctl[SQRT_CELLS];
    assign dv_root[0] = sq_r[SQRT_CELLS][ROOT_W-1:0];
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dv_rem[0][c] = (NUM_W'(sq_m[SQRT_CELLS][c]) << NORMAL_FRAC_BITS)
                         + NUM_W'(sq_r[SQRT_CELLS][ROOT_W-1:1]);
            dv_q[0][c]   = '0;
        end
    end

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        unu_div_cell #(.I(DIV_CELLS - 1 - j)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (dv_ctl[j]),
            .root_in  (dv_root[j]),
            .rem_in   (dv_rem[j]),
            .q_in     (dv_q[j]),
            .ctl_out  (dv_ctl[j+1]),
            .root_out (dv_root[j+1]),
            .rem_out  (dv_rem[j+1]),
            .q_out    (dv_q[j+1])
        );
    end

    // saturate, reapply sign, fallback for zero length
    always_comb
    begin
        last_ctl = dv_ctl[DIV_CELLS];
        for (int c = 0; c < 3; c++)
        begin
            q_sat[c] = (dv_q[DIV_CELLS][c] > ONE_Q) ? ONE_Q : dv_q[DIV_CELLS][c];
            comp[c]  = last_ctl.neg[c] ? (OUT_W'(0) - OUT_W'(q_sat[c]))
                                       : OUT_W'(q_sat[c]);
        end
        if (last_ctl.degen)
        begin
            out_next.normal_x   = '0;
            out_next.normal_y   = '0;
            out_next.normal_z   = (last_ctl.op == OP_3D) ? ONE_OUT : '0;
            out_next.degenerate = 1'b1;
        end
        else
        begin
            out_next.normal_x   = comp[0];
            out_next.normal_y   = comp[1];
            out_next.normal_z   = (last_ctl.op == OP_3D) ? comp[2] : '0;
            out_next.degenerate = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= last_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

// File: tb/tb_unit_normal.sv
// tb: self-checking bench for unit_normal_unit_core, directed table then random points
// depends on unu_pkg, unu_if and the rtl under rtl/core
`timescale 1ns / 1ps

module tb;
    import unu_pkg::*;

    localparam int LATENCY = 54;

    logic clk;
    logic rst_n;
    int   errors;
    bit   stim_done;

    unu_in_if  req ();
    unu_out_if rsp ();

    unu_out_t normal_q[$];

    typedef struct {
        unu_in_t  item;
        bit       known;
        unu_out_t result;
    } dir_row_t;

    unit_normal_unit_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [15:0] scale_component(logic [29:0] m, logic neg,
                                                    logic [31:0] root);
        logic [63:0] q;
        begin
            q = ((64'(m) << NORMAL_FRAC_BITS) + 64'(root >> 1)) / 64'(root);
            if (q > (64'd1 << NORMAL_FRAC_BITS))
                q = 64'd1 << NORMAL_FRAC_BITS;
            return neg ? 16'(-q) : 16'(q);
        end
    endfunction

    function automatic unu_out_t predict_normal(unu_in_t it);
        logic signed [24:0]  e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [127:0] c [3];
        logic [127:0]        mag [3];
        logic [127:0]        any_bits;
        logic [29:0]         m [3];
        logic [63:0]         s;
        logic [63:0]         root;
        logic [63:0]         bit_w;
        logic [63:0]         v;
        int                  len;
        unu_out_t            o;
        begin
            e1x = 25'(it.bx) - 25'(it.ax);
            e1y = 25'(it.by_coord) - 25'(it.ay);
            e1z = 25'(it.bz) - 25'(it.az);
            e2x = 25'(it.dx) - 25'(it.ax);
            e2y = 25'(it.dy) - 25'(it.ay);
            e2z = 25'(it.dz) - 25'(it.az);
            if (it.op == OP_3D)
            begin
                c[0] = 128'(e1y) * 128'(e2z) - 128'(e1z) * 128'(e2y);
                c[1] = 128'(e1z) * 128'(e2x) - 128'(e1x) * 128'(e2z);
                c[2] = 128'(e1x) * 128'(e2y) - 128'(e1y) * 128'(e2x);
            end
            else
            begin
                c[0] = 128'(e1y);
                c[1] = -128'(e1x);
                c[2] = '0;
            end
            any_bits = '0;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = c[i][127] ? 128'(-c[i]) : 128'(c[i]);
                any_bits |= mag[i];
            end
            len = 0;
            for (int i = 0; i < 128; i++)
                if (any_bits[i])
                    len = i + 1;
            o = '0;
            if (len == 0)
            begin
                o.normal_z   = (it.op == OP_3D) ? 16'sd16384 : 16'sd0;
                o.degenerate = 1'b1;
                return o;
            end
            for (int i = 0; i < 3; i++)
                m[i] = (len > 30) ? 30'(mag[i] >> (len - 30)) : 30'(mag[i] << (30 - len));
            s = 64'(m[0]) * m[0] + 64'(m[1]) * m[1] + 64'(m[2]) * m[2];
            root  = 0;
            bit_w = 64'd1 << 62;
            v     = s;
            while (bit_w > v)
                bit_w >>= 2;
            while (bit_w != 0)
            begin
                if (v >= root + bit_w)
                begin
                    v    = v - (root + bit_w);
                    root = (root >> 1) + bit_w;
                end
                else
                    root >>= 1;
                bit_w >>= 2;
            end
            o.normal_x = scale_component(m[0], c[0][127], 32'(root));
            o.normal_y = scale_component(m[1], c[1][127], 32'(root));
            o.normal_z = (it.op == OP_3D) ? scale_component(m[2], c[2][127], 32'(root)) : '0;
            return o;
        end
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        begin
            $display("mismatch on %s: got %0d expected %0d", field, got, want);
            errors++;
        end
    endtask

    function automatic logic [23:0] rand_coord();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                return 24'h800000;
            if (sel == 1)
                return 24'h7fffff;
            if (sel < 5)
                return 24'($signed($urandom_range(0, 64)) - 32);
            return 24'($urandom);
        end
    endfunction

    function automatic unu_in_t rand_item();
        unu_in_t it;
        begin
            it.op = 1'($urandom_range(0, 1));
            it.ax = rand_coord();
            it.ay = rand_coord();
            it.az = rand_coord();
            it.bx = rand_coord();
            it.by_coord = rand_coord();
            it.bz = rand_coord();
            it.dx = rand_coord();
            it.dy = rand_coord();
            it.dz = rand_coord();
            case ($urandom_range(0, 11))
                0: begin it.bx = it.ax; it.by_coord = it.ay; it.bz = it.az; end
                1: begin it.dx = it.ax; it.dy = it.ay; it.dz = it.az; end
                2: begin it.dx = it.bx; it.dy = it.by_coord; it.dz = it.bz; end
                default: ;
            endcase
            return it;
        end
    endfunction

    function automatic int gap_len();
        begin
            if ($urandom_range(0, 2) != 0)
                return 0;
            if ($urandom_range(0, 9) == 0)
                return $urandom_range(5, 30);
            return $urandom_range(1, 3);
        end
    endfunction

    task automatic send_item(unu_in_t it);
        begin
            req.valid <= 1'b1;
            req.data  <= it;
            do
                @(posedge clk);
            while (!req.ready);
            @(negedge clk);
        end
    endtask

    function automatic unu_in_t mk(logic op, int ax, int ay, int az, int bx, int by,
                                   int bz, int dx, int dy, int dz);
        unu_in_t it;
        begin
            it.op = op;
            it.ax = 24'(ax); it.ay = 24'(ay); it.az = 24'(az);
            it.bx = 24'(bx); it.by_coord = 24'(by); it.bz = 24'(bz);
            it.dx = 24'(dx); it.dy = 24'(dy); it.dz = 24'(dz);
            return it;
        end
    endfunction

    function automatic unu_out_t res(int x, int y, int z, logic d);
        unu_out_t o;
        begin
            o.normal_x = 16'(x);
            o.normal_y = 16'(y);
            o.normal_z = 16'(z);
            o.degenerate = d;
            return o;
        end
    endfunction

    // feeder
    initial
    begin
        dir_row_t rows[$];
        int       gap;
        unu_out_t want;
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.data  = '0;
        errors    = 0;
        stim_done = 0;
        rows.insert(rows.size(), '{mk(OP_3D, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                                   res(0, 0, 16384, 1)});
        rows.insert(rows.size(), '{mk(OP_2D, 5, 7, 1, 5, 7, 9, 3, 3, 3), 1,
                                   res(0, 0, 0, 1)});
        rows.insert(rows.size(), '{mk(OP_3D, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1,
                                   res(0, 0, 16384, 0)});
        rows.insert(rows.size(), '{mk(OP_3D, 0, 0, 0, 0, 4096, 0, 4096, 0, 0), 1,
                                   res(0, 0, -16384, 0)});
        rows.insert(rows.size(), '{mk(OP_2D, 0, 0, 0, 4096, 0, 0, 0, 0, 0), 1,
                                   res(0, -16384, 0, 0)});
        rows.insert(rows.size(), '{mk(OP_2D, 0, 0, 0, 0, 4096, 0, 0, 0, 0), 1,
                                   res(16384, 0, 0, 0)});
        rows.insert(rows.size(), '{mk(OP_3D, 1, 2, 3, 2, 4, 6, 3, 6, 9), 1,
                                   res(0, 0, 16384, 1)});
        rows.insert(rows.size(), '{mk(OP_2D, -8388608, -8388608, 0, 8388607, 8388607,
                                      0, 0, 0, 0), 0, '0});
        rows.insert(rows.size(), '{mk(OP_2D, 8388607, -8388608, -1, -8388608, 8388607,
                                      5, 1, 1, 1), 0, '0});
        rows.insert(rows.size(), '{mk(OP_3D, -8388608, -8388608, -8388608, 8388607,
                                      -8388608, -8388608, -8388608, 8388607, -8388608),
                                   0, '0});
        rows.insert(rows.size(), '{mk(OP_3D, 8388607, 8388607, 8388607, -8388608,
                                      8388607, 8388607, 8388607, -8388608, -8388608),
                                   0, '0});
        rows.insert(rows.size(), '{mk(OP_3D, -1, -1, -1, 0, -1, -1, -1, 0, -1), 0, '0});
        rows.insert(rows.size(), '{mk(OP_3D, 0, 0, 0, 1, 0, 0, 0, 8388607, 1), 0, '0});
        rows.insert(rows.size(), '{mk(OP_2D, 0, 0, 0, 3, -4, 0, 0, 0, 0), 0, '0});
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (rows[i])
        begin
            want = rows[i].known ? rows[i].result : predict_normal(rows[i].item);
            if (rows[i].known && want != predict_normal(rows[i].item))
                $display("table row %0d disagrees with prediction", i);
            normal_q.insert(normal_q.size(), want);
            send_item(rows[i].item);
        end
        for (int n = 0; n < 600; n++)
        begin
            unu_in_t it;
            gap = gap_len();
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap)
                    @(negedge clk);
            end
            it = rand_item();
            normal_q.insert(normal_q.size(), predict_normal(it));
            send_item(it);
        end
        req.valid <= 1'b0;
        stim_done = 1;
    end

    // result side back-pressure
    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = gap_len();
            if (gap != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap - 1)
                    @(negedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (normal_q.size() == 0)
            begin
                $display("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                unu_out_t want;
                want = normal_q.pop_front();
                if (rsp.data.normal_x !== want.normal_x)
                    report_mismatch("normal_x", int'(rsp.data.normal_x),
                                    int'(want.normal_x));
                if (rsp.data.normal_y !== want.normal_y)
                    report_mismatch("normal_y", int'(rsp.data.normal_y),
                                    int'(want.normal_y));
                if (rsp.data.normal_z !== want.normal_z)
                    report_mismatch("normal_z", int'(rsp.data.normal_z),
                                    int'(want.normal_z));
                if (rsp.data.degenerate !== want.degenerate)
                    report_mismatch("degenerate", int'(rsp.data.degenerate),
                                    int'(want.degenerate));
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (normal_q.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY)
            @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/unu_pkg.sv
rtl/core/unu_if.sv
rtl/core/unu_front.sv
rtl/core/unu_sqrt_cell.sv
rtl/core/unu_div_cell.sv
rtl/core/unit_normal_unit_core.sv
tb/tb_unit_normal.sv
